// File: rtl/metronome_beat_tracker_assert.svh
// Assertion macros for the metronome beat tracker.
// Used by the RTL modules; no other dependencies.
`ifndef METRONOME_BEAT_TRACKER_ASSERT_SVH
`define METRONOME_BEAT_TRACKER_ASSERT_SVH

// Property checked on the rising clock, off while reset is asserted.
`define MBT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the rising clock, off while reset is asserted.
`define MBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/mbt_pkg.sv
// Types, constants and the cosine polynomial for the metronome beat tracker.
// No dependencies.
package mbt_pkg;

  localparam int QUEUE_DEPTH_DEF       = 4;
  localparam int PERIOD_CANDIDATES_DEF = 3;
  localparam int PHASE_CANDIDATES_DEF  = 7;
  localparam int COS_TABLE_BITS_DEF    = 10;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  localparam int PH_LIMIT   = 1000000;
  localparam int PER_CEIL   = 8191;
  localparam int DIV_STEPS  = 34;
  localparam int DIV_CNT_W  = 6;

  localparam longint ONE_Q28 = 268435456;
  localparam longint CF1     = 331168970;
  localparam longint CF2     = 68093890;
  localparam longint CF3     = 5600498;
  localparam longint CF4     = 246762;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REJECT = 3'd0,
    CFG_PSTEP  = 3'd1,
    CFG_PHSTEP = 3'd2,
    CFG_PINIT  = 3'd3,
    CFG_PMIN   = 3'd4,
    CFG_PMAX   = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRESS,
    ST_TICK,
    ST_CAND,
    ST_LOADR,
    ST_DIVR,
    ST_MODF,
    ST_DIVA,
    ST_ACC,
    ST_CMP,
    ST_APPLY,
    ST_NXT,
    ST_DIVN,
    ST_MUL,
    ST_FIN
  } state_e;

  // Q15 cosine over one quadrant; w is Q14 of a quarter turn.
  function automatic logic [14:0] quarter_cos(input longint w);
    longint s;
    longint p;
    s = w * w;
    p = CF3 - ((CF4 * s) >>> 28);
    p = CF2 - ((p * s) >>> 28);
    p = CF1 - ((p * s) >>> 28);
    p = ONE_Q28 - ((p * s) >>> 28);
    if (p < 0) p = 0;
    p = (p + 4096) >>> 13;
    if (p > 32767) p = 32767;
    return p[14:0];
  endfunction

endpackage

// File: rtl/metronome_beat_tracker.sv
// Metronome beat tracker top level: press queue, adjustment search and beat prediction.
// Depends on mbt_pkg and metronome_beat_tracker_assert.svh.
//
// One item at a time. A tick, when the newest press has changed, first runs the search
// over PERIOD_CANDIDATES * PHASE_CANDIDATES candidates and the n queued presses. The
// search uses one shared bit-serial divider, twice per press and candidate (modulo,
// then turn angle), and the divider is used once more for the prediction. Results wait
// in an output register; a new item is taken once the previous result is loaded there.
`include "metronome_beat_tracker_assert.svh"

module metronome_beat_tracker #(
  parameter int QUEUE_DEPTH       = mbt_pkg::QUEUE_DEPTH_DEF,
  parameter int PERIOD_CANDIDATES = mbt_pkg::PERIOD_CANDIDATES_DEF,
  parameter int PHASE_CANDIDATES  = mbt_pkg::PHASE_CANDIDATES_DEF,
  parameter int COS_TABLE_BITS    = mbt_pkg::COS_TABLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            mode_i,
  input  logic [31:0]                     time_ms_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            accepted_o,
  output logic                            updated_o,
  output logic [12:0]                     period_ms_o,
  output logic signed [20:0]              phase_ms_o,
  output logic signed [32:0]              next_beat_ms_o,
  input  logic                            cfg_we_i,
  input  logic [mbt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mbt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);
  import mbt_pkg::*;

  localparam int KW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PCW = (PERIOD_CANDIDATES > 1) ? $clog2(PERIOD_CANDIDATES) : 1;
  localparam int JCW = (PHASE_CANDIDATES > 1) ? $clog2(PHASE_CANDIDATES) : 1;
  localparam int SW  = 16 + CW;
  localparam int QN  = 1 << (COS_TABLE_BITS - 2);

  // configuration
  logic [9:0]  thr_q, thr_d;
  logic [6:0]  pstep_q, pstep_d;
  logic [6:0]  phstep_q, phstep_d;
  logic [11:0] pmin_q, pmin_d;
  logic [12:0] pmax_q, pmax_d;

  // tracker state
  state_e             state_q, state_d;
  logic [31:0]        press_q [QUEUE_DEPTH];
  logic [31:0]        press_d [QUEUE_DEPTH];
  logic [CW-1:0]      cnt_q, cnt_d;
  logic [31:0]        newest_q, newest_d;
  logic [31:0]        seen_q, seen_d;
  logic [12:0]        per_q, per_d;
  logic signed [20:0] ph_q, ph_d;
  logic signed [32:0] last_q, last_d;

  // item and search
  logic [31:0]        time_q, time_d;
  logic               upd_q, upd_d;
  logic [PCW-1:0]     pi_q, pi_d;
  logic [JCW-1:0]     ji_q, ji_d;
  logic [KW-1:0]      k_q, k_d;
  logic [12:0]        cper_q, cper_d;
  logic signed [20:0] cph_q, cph_d;
  logic [SW-1:0]      sum_q, sum_d;
  logic [SW-1:0]      bsum_q, bsum_d;
  logic [12:0]        bper_q, bper_d;
  logic signed [20:0] bph_q, bph_d;
  logic               have_q, have_d;

  // shared divider and multiplier
  logic [12:0]          rem_q, rem_d;
  logic [33:0]          quo_q, quo_d;
  logic [12:0]          den_q, den_d;
  logic [DIV_CNT_W-1:0] dcnt_q, dcnt_d;
  logic                 xneg_q, xneg_d;
  logic signed [48:0]   prod_q, prod_d;

  // result register
  logic               outv_q, outv_d;
  logic               oacc_q, oacc_d;
  logic               oupd_q, oupd_d;
  logic [12:0]        oper_q, oper_d;
  logic signed [20:0] oph_q, oph_d;
  logic signed [32:0] onext_q, onext_d;

  logic [14:0] qtab [QN+1];

  for (genvar g = 0; g <= QN; g++) begin : g_qtab
    assign qtab[g] = quarter_cos(longint'(g) << (16 - COS_TABLE_BITS));
  end

  logic [31:0] newest;
  logic        changed;
  logic        out_free;
  logic        last_k;
  logic        last_cand;

  assign newest    = (cnt_q != '0) ? newest_q : 32'd0;
  assign changed   = (newest != seen_q);
  assign out_free  = !outv_q || !out_stall_i;
  assign last_k    = ((CW'(k_q) + CW'(1)) == cnt_q);
  assign last_cand = (pi_q == PCW'(PERIOD_CANDIDATES - 1)) &&
                     (ji_q == JCW'(PHASE_CANDIDATES - 1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = mode_i ? ST_TICK : ST_PRESS;
      ST_PRESS: if (out_free) state_d = ST_IDLE;
      ST_TICK:  state_d = changed ? ST_CAND : ST_NXT;
      ST_CAND:  state_d = (cnt_q == '0) ? ST_CMP : ST_LOADR;
      ST_LOADR: state_d = ST_DIVR;
      ST_DIVR:  if (dcnt_q == DIV_CNT_W'(1)) state_d = ST_MODF;
      ST_MODF:  state_d = ST_DIVA;
      ST_DIVA:  if (dcnt_q == DIV_CNT_W'(1)) state_d = ST_ACC;
      ST_ACC:   state_d = last_k ? ST_CMP : ST_LOADR;
      ST_CMP:   state_d = last_cand ? ST_APPLY : ST_CAND;
      ST_APPLY: state_d = ST_NXT;
      ST_NXT:   state_d = ST_DIVN;
      ST_DIVN:  if (dcnt_q == DIV_CNT_W'(1)) state_d = ST_MUL;
      ST_MUL:   state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // candidate generation
  logic [PCW:0]       pm;
  logic [JCW:0]       jm;
  logic signed [15:0] pmag, pcand;
  logic signed [21:0] jmag, jcand;
  logic [12:0]        pclamp;
  logic signed [20:0] jclamp;

  always_comb begin
    pm    = (PCW+1)'(({1'b0, pi_q} + (PCW+1)'(1)) >> 1);
    jm    = (JCW+1)'(({1'b0, ji_q} + (JCW+1)'(1)) >> 1);
    pmag  = 16'(16'(pm) * 16'(pstep_q));
    jmag  = 22'(22'(jm) * 22'(phstep_q));
    pcand = $signed({3'b0, per_q}) + (pi_q[0] ? pmag : -pmag);
    jcand = 22'(ph_q) + (ji_q[0] ? jmag : -jmag);
    if (pcand < $signed({4'b0, pmin_q})) pcand = $signed({4'b0, pmin_q});
    if (pcand > $signed({3'b0, pmax_q})) pcand = $signed({3'b0, pmax_q});
    if (pcand < 16'sd1) pcand = 16'sd1;
    if (pcand > 16'(PER_CEIL)) pcand = 16'(PER_CEIL);
    pclamp = pcand[12:0];
    if (jcand < -22'(PH_LIMIT)) jclamp = -21'(PH_LIMIT);
    else if (jcand > 22'(PH_LIMIT)) jclamp = 21'(PH_LIMIT);
    else jclamp = jcand[20:0];
  end

  // divider step, dividend magnitudes, cosine and error
  logic [13:0]        rem_s;
  logic               ge;
  logic signed [33:0] xr, xn;
  logic [12:0]        rmod;
  logic [COS_TABLE_BITS-1:0] cidx;
  logic [1:0]         quad;
  logic [COS_TABLE_BITS-2:0] cm;
  logic signed [17:0] c18, e1, e2, e3, emin;
  logic signed [34:0] fac;

  always_comb begin
    rem_s = {rem_q, quo_q[33]};
    ge    = (rem_s >= {1'b0, den_q});
    xr    = $signed({2'b0, press_q[k_q]}) + 34'(cph_q);
    xn    = $signed({2'b0, time_q}) + 34'(ph_q);
    rmod  = (xneg_q && rem_q != '0) ? den_q - rem_q : rem_q;
    cidx  = quo_q[15 -: COS_TABLE_BITS];
    quad  = cidx[COS_TABLE_BITS-1 -: 2];
    cm    = quad[0] ? (COS_TABLE_BITS-1)'(QN) - {1'b0, cidx[COS_TABLE_BITS-3:0]}
                    : {1'b0, cidx[COS_TABLE_BITS-3:0]};
    c18   = (quad == 2'd1 || quad == 2'd2) ? -$signed({3'b0, qtab[cm]})
                                           : $signed({3'b0, qtab[cm]});
    e1    = (18'sd32768 - c18) >>> 2;
    e2    = (c18 + 18'sd32768) >>> 1;
    e3    = (c18 < 0) ? -c18 : c18;
    emin  = (e1 < e2) ? e1 : e2;
    if (e3 < emin) emin = e3;
    fac   = xneg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  end

  // prediction finish
  logic signed [49:0] nx;
  logic signed [32:0] nsat, nfin;
  logic signed [33:0] dd;
  logic [33:0]        ad;

  always_comb begin
    nx = 50'(prod_q) - 50'(ph_q);
    if (nx > 50'sd4294967295) nsat = 33'sh0FFFFFFFF;
    else if (nx < -50'sd4294967296) nsat = 33'sh100000000;
    else nsat = nx[32:0];
    dd   = 34'(nsat) - 34'(last_q);
    ad   = dd[33] ? 34'(-dd) : 34'(dd);
    nfin = (ad != '0 && {ad, 1'b0} < 35'(per_q)) ? last_q : nsat;
  end

  // press acceptance
  logic signed [32:0] pdiff;
  logic               pok;
  assign pdiff = $signed({1'b0, time_q}) - $signed({1'b0, newest});
  assign pok   = (cnt_q == '0) || (pdiff >= $signed({23'b0, thr_q}));

  // datapath and outputs
  always_comb begin
    thr_d = thr_q; pstep_d = pstep_q; phstep_d = phstep_q;
    pmin_d = pmin_q; pmax_d = pmax_q;
    press_d = press_q; cnt_d = cnt_q; newest_d = newest_q; seen_d = seen_q;
    per_d = per_q; ph_d = ph_q; last_d = last_q;
    time_d = time_q; upd_d = upd_q;
    pi_d = pi_q; ji_d = ji_q; k_d = k_q; cper_d = cper_q; cph_d = cph_q;
    sum_d = sum_q; bsum_d = bsum_q; bper_d = bper_q; bph_d = bph_q; have_d = have_q;
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; dcnt_d = dcnt_q; xneg_d = xneg_q;
    prod_d = prod_q;
    outv_d = outv_q && out_stall_i;
    oacc_d = oacc_q; oupd_d = oupd_q; oper_d = oper_q; oph_d = oph_q; onext_d = onext_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          time_d = time_ms_i;
        end
      end
      ST_PRESS: begin
        if (out_free) begin
          if (pok) begin
            if (cnt_q == CW'(QUEUE_DEPTH)) begin
              for (int i = 0; i < QUEUE_DEPTH - 1; i++) press_d[i] = press_q[i + 1];
              press_d[QUEUE_DEPTH-1] = time_q;
            end else begin
              press_d[cnt_q[KW-1:0]] = time_q;
              cnt_d = cnt_q + CW'(1);
            end
            newest_d = time_q;
          end
          outv_d  = 1'b1;
          oacc_d  = pok;
          oupd_d  = 1'b0;
          oper_d  = per_q;
          oph_d   = ph_q;
          onext_d = '0;
        end
      end
      ST_TICK: begin
        seen_d = newest;
        upd_d  = changed;
        pi_d   = '0;
        ji_d   = '0;
        have_d = 1'b0;
      end
      ST_CAND: begin
        cper_d = pclamp;
        cph_d  = jclamp;
        sum_d  = '0;
        k_d    = '0;
      end
      ST_LOADR: begin
        xneg_d = xr[33];
        quo_d  = xr[33] ? 34'(-xr) : 34'(xr);
        rem_d  = '0;
        den_d  = cper_q;
        dcnt_d = DIV_CNT_W'(DIV_STEPS);
      end
      ST_DIVR, ST_DIVA, ST_DIVN: begin
        rem_d  = ge ? 13'(rem_s - {1'b0, den_q}) : rem_s[12:0];
        quo_d  = {quo_q[32:0], ge};
        dcnt_d = dcnt_q - DIV_CNT_W'(1);
      end
      ST_MODF: begin
        quo_d  = {5'b0, rmod, 16'b0};
        rem_d  = '0;
        dcnt_d = DIV_CNT_W'(DIV_STEPS);
      end
      ST_ACC: begin
        sum_d = sum_q + SW'(emin[15:0]);
        k_d   = k_q + KW'(1);
      end
      ST_CMP: begin
        if (!have_q || sum_q < bsum_q) begin
          bsum_d = sum_q;
          bper_d = cper_q;
          bph_d  = cph_q;
        end
        have_d = 1'b1;
        if (ji_q == JCW'(PHASE_CANDIDATES - 1)) begin
          ji_d = '0;
          pi_d = pi_q + PCW'(1);
        end else begin
          ji_d = ji_q + JCW'(1);
        end
      end
      ST_APPLY: begin
        per_d = bper_q;
        ph_d  = bph_q;
      end
      ST_NXT: begin
        xneg_d = xn[33];
        quo_d  = xn[33] ? 34'(-xn) : 34'(xn);
        rem_d  = '0;
        den_d  = per_q;
        dcnt_d = DIV_CNT_W'(DIV_STEPS);
      end
      ST_MUL: begin
        prod_d = (fac + 35'sd1) * $signed({1'b0, per_q});
      end
      ST_FIN: begin
        if (out_free) begin
          last_d  = nfin;
          outv_d  = 1'b1;
          oacc_d  = 1'b0;
          oupd_d  = upd_q;
          oper_d  = per_q;
          oph_d   = ph_q;
          onext_d = nfin;
        end
      end
      default: ;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REJECT: thr_d    = cfg_wdata_i[9:0];
        CFG_PSTEP:  pstep_d  = cfg_wdata_i[6:0];
        CFG_PHSTEP: phstep_d = cfg_wdata_i[6:0];
        CFG_PINIT: begin
          per_d = (cfg_wdata_i[11:0] == '0) ? 13'd1 : {1'b0, cfg_wdata_i[11:0]};
        end
        CFG_PMIN:   pmin_d   = cfg_wdata_i[11:0];
        CFG_PMAX:   pmax_d   = cfg_wdata_i[12:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      thr_q    <= 10'd42;
      pstep_q  <= 7'd10;
      phstep_q <= 7'd10;
      pmin_q   <= 12'd100;
      pmax_q   <= 13'd4000;
      cnt_q    <= '0;
      seen_q   <= '0;
      per_q    <= 13'd667;
      ph_q     <= '0;
      last_q   <= '0;
      outv_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      thr_q    <= thr_d;
      pstep_q  <= pstep_d;
      phstep_q <= phstep_d;
      pmin_q   <= pmin_d;
      pmax_q   <= pmax_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      per_q    <= per_d;
      ph_q     <= ph_d;
      last_q   <= last_d;
      outv_q   <= outv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    press_q  <= press_d;
    newest_q <= newest_d;
    time_q   <= time_d;
    upd_q    <= upd_d;
    pi_q     <= pi_d;
    ji_q     <= ji_d;
    k_q      <= k_d;
    cper_q   <= cper_d;
    cph_q    <= cph_d;
    sum_q    <= sum_d;
    bsum_q   <= bsum_d;
    bper_q   <= bper_d;
    bph_q    <= bph_d;
    have_q   <= have_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    dcnt_q   <= dcnt_d;
    xneg_q   <= xneg_d;
    prod_q   <= prod_d;
    oacc_q   <= oacc_d;
    oupd_q   <= oupd_d;
    oper_q   <= oper_d;
    oph_q    <= oph_d;
    onext_q  <= onext_d;
  end

  assign in_stall_o     = (state_q != ST_IDLE);
  assign out_valid_o    = outv_q;
  assign accepted_o     = oacc_q;
  assign updated_o      = oupd_q;
  assign period_ms_o    = oper_q;
  assign phase_ms_o     = oph_q;
  assign next_beat_ms_o = onext_q;

  `MBT_ASSERT_IMP(a_take, clk_i, rst_ni, in_valid_i && !in_stall_o, ##1 in_stall_o, "item idle")
  `MBT_ASSERT(a_period_nonzero, clk_i, rst_ni, per_q != '0, "tracked period is zero")
  `MBT_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= CW'(QUEUE_DEPTH), "press count beyond depth")
  `MBT_ASSERT_IMP(a_acc_in_queue, clk_i, rst_ni, state_q == ST_ACC, CW'(k_q) < cnt_q, "bad press")
  `MBT_ASSERT(a_phase_bound, clk_i, rst_ni, ph_q <= 21'sd1000000 && ph_q >= -21'sd1000000, "phase")

endmodule
